>>> design/gdc_pkg.sv
// Shared types and constants for the group dimmer controller.
// Holds command codes, register indexes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package gdc_pkg;

  // Input command codes.
  localparam logic [2:0] CMD_TOGGLE   = 3'd0;
  localparam logic [2:0] CMD_INCREASE = 3'd1;
  localparam logic [2:0] CMD_DECREASE = 3'd2;
  localparam logic [2:0] CMD_REPORT   = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_MAX     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] TIMEOUT_RESET = 16'd600;
  localparam logic [4:0]  COUNT_RESET   = 5'd16;
  localparam logic [7:0]  MAX_RESET     = 8'd255;

  // Saturation value of the idle counter.
  localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

  // Level store write selection.
  localparam logic [1:0] WR_NONE   = 2'd0;
  localparam logic [1:0] WR_FILL   = 2'd1;
  localparam logic [1:0] WR_APPLY  = 2'd2;
  localparam logic [1:0] WR_REPORT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       op_ld;
    logic       cur_clr;
    logic       cur_inc;
    logic       rd_en;
    logic       acc_init;
    logic       acc_en;
    logic [1:0] wr_sel;
    logic       emit;
    logic       tick;
    logic       sched;
    logic       idle_clr;
  } gdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_done;
    logic rd_vld;
    logic dirty_cur;
    logic pending;
    logic cnt_zero;
    logic idle_gt;
    logic rpt_ok;
    logic out_free;
    logic op_toggle;
  } gdc_status_t;

endpackage

`default_nettype wire

>>> design/gdc_ctrl.sv
// Controller state machine of the group dimmer controller.
// Sequences scans, fills, sends and timer updates; depends on gdc_pkg.
`default_nettype none

module gdc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [2:0]         in_cmd,
  output logic                    in_stall,
  input  wire gdc_pkg::gdc_status_t st,
  output gdc_pkg::gdc_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_REQ   = 3'd4;
  localparam logic [2:0] ST_BRD   = 3'd5;
  localparam logic [2:0] ST_BWR   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wr_sel = gdc_pkg::WR_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.op_ld = 1'b1;
          unique case (in_cmd)
            gdc_pkg::CMD_TOGGLE, gdc_pkg::CMD_INCREASE, gdc_pkg::CMD_DECREASE: begin
              cmd.cur_clr  = 1'b1;
              cmd.acc_init = 1'b1;
              state_nxt    = ST_SCAN;
            end
            gdc_pkg::CMD_REPORT: begin
              if (st.rpt_ok) cmd.wr_sel = gdc_pkg::WR_REPORT;
            end
            gdc_pkg::CMD_TICK: begin
              cmd.tick = 1'b1;
              if (st.pending && st.cnt_zero) begin
                cmd.cur_clr = 1'b1;
                state_nxt   = ST_BRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Reads are issued back to back; the last one drains in the cycle after it.
        cmd.acc_en  = 1'b1;
        cmd.rd_en   = !st.cur_done;
        cmd.cur_inc = !st.cur_done;
        if (st.cur_done && !st.rd_vld) begin
          if (st.op_toggle) begin
            cmd.cur_clr = 1'b1;
            state_nxt   = ST_FILL;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_FILL: begin
        if (st.cur_done) begin
          state_nxt = ST_REQ;
        end else begin
          cmd.wr_sel  = gdc_pkg::WR_FILL;
          cmd.cur_inc = 1'b1;
        end
      end
      ST_APPLY: begin
        cmd.wr_sel = gdc_pkg::WR_APPLY;
        state_nxt  = ST_REQ;
      end
      ST_REQ: begin
        priority if (st.pending) begin
          state_nxt = ST_IDLE;
        end else if (st.idle_gt) begin
          cmd.cur_clr = 1'b1;
          state_nxt   = ST_BRD;
        end else begin
          cmd.sched = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_BRD: begin
        priority if (st.cur_done) begin
          cmd.idle_clr = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (st.dirty_cur) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_BWR;
        end else begin
          cmd.cur_inc = 1'b1;
        end
      end
      ST_BWR: begin
        // Read data stays in the output latch of the store until the transfer slot frees.
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cur_inc = 1'b1;
          state_nxt   = ST_BRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/gdc_datapath.sv
// Datapath of the group dimmer controller: level store, dirty marks,
// scan accumulators, send timer and the result register. Depends on gdc_pkg.
`default_nettype none

module gdc_datapath #(
  parameter int MEMBERS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [15:0]       timeout_ticks,
  input  wire logic [4:0]        member_count,
  input  wire logic [7:0]        max_level,
  input  wire logic [2:0]        in_cmd,
  input  wire logic [3:0]        in_member,
  input  wire logic [7:0]        in_level,
  input  wire gdc_pkg::gdc_cmd_t cmd,
  output gdc_pkg::gdc_status_t   st,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             out_member_res,
  output logic [7:0]             out_level_res,
  output logic                   out_last
);

  localparam int IW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
  localparam int CW = $clog2(MEMBERS + 1);

  logic [7:0]         mem [MEMBERS];
  logic [MEMBERS-1:0] lvl_vld_r;
  logic [MEMBERS-1:0] dirty_r;
  logic [7:0]         mem_q_r;
  logic               q_vld_r;
  logic               rd_vld_r;
  logic [IW-1:0]      rd_idx_r;
  logic [CW-1:0]      cursor_r;
  logic [CW-1:0]      n_use;
  logic [7:0]         mc8;
  logic [7:0]         cur8;
  logic [7:0]         mbr8;
  logic [IW-1:0]      cur_idx;
  logic [7:0]         rd_level;
  logic [2:0]         op_r;
  logic [7:0]         acc_lvl_r;
  logic [IW-1:0]      acc_idx_r;
  logic               acc_first_r;
  logic               lit_r;
  logic               pending_r;
  logic [15:0]        cnt_r;
  logic [16:0]        idle_r;
  logic               out_valid_r;
  logic [3:0]         out_member_r;
  logic [7:0]         out_level_r;
  logic               out_last_r;
  logic               more_dirty;
  logic               apply_ok;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [7:0]         wr_data;

  // Lamps in use: zero counts as one, large values clamp to the store depth.
  assign mc8 = {3'b000, member_count};
  always_comb begin
    priority if (mc8 == 8'd0) begin
      n_use = CW'(1);
    end else if (mc8 > 8'(MEMBERS)) begin
      n_use = CW'(MEMBERS);
    end else begin
      n_use = CW'(mc8);
    end
  end

  assign cur8     = 8'(cursor_r);
  assign mbr8     = 8'(in_member);
  assign cur_idx  = cur8[IW-1:0];
  assign rd_level = q_vld_r ? mem_q_r : 8'd0;

  // Any dirty lamp in use beyond the cursor decides the last flag.
  always_comb begin
    more_dirty = 1'b0;
    for (int j = 0; j < MEMBERS; j++) begin
      if (dirty_r[j] && (CW'(j) > cursor_r) && (CW'(j) < n_use)) more_dirty = 1'b1;
    end
  end

  // Write port selection.
  assign apply_ok = (op_r == gdc_pkg::CMD_INCREASE) ? (acc_lvl_r < max_level)
                                                    : (acc_lvl_r != 8'd0);
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = in_level;
    unique case (cmd.wr_sel)
      gdc_pkg::WR_FILL: begin
        wr_en   = 1'b1;
        wr_data = lit_r ? 8'd0 : max_level;
      end
      gdc_pkg::WR_APPLY: begin
        wr_en   = apply_ok;
        wr_addr = acc_idx_r;
        wr_data = (op_r == gdc_pkg::CMD_INCREASE) ? (acc_lvl_r + 8'd1) : (acc_lvl_r - 8'd1);
      end
      gdc_pkg::WR_REPORT: begin
        wr_en   = 1'b1;
        wr_addr = mbr8[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Level store with registered read at the cursor.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      mem_q_r  <= mem[cur_idx];
      q_vld_r  <= lvl_vld_r[cur_idx];
      rd_idx_r <= cur_idx;
    end
  end

  // Written marks stand in for the all-zero reset of the store; dirty marks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_vld_r <= '0;
      dirty_r   <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (wr_en) begin
        lvl_vld_r[wr_addr] <= 1'b1;
        dirty_r[wr_addr]   <= (cmd.wr_sel != gdc_pkg::WR_REPORT);
      end
      if (cmd.emit) dirty_r[cur_idx] <= 1'b0;
    end
  end

  // Cursor and latched operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      op_r     <= gdc_pkg::CMD_TOGGLE;
    end else begin
      if (cmd.op_ld) op_r <= in_cmd;
      priority if (cmd.cur_clr) begin
        cursor_r <= '0;
      end else if (cmd.cur_inc) begin
        cursor_r <= cursor_r + CW'(1);
      end
    end
  end

  // Scan accumulators: dimmest with lowest index, brightest with highest index.
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc_first_r <= 1'b1;
      lit_r       <= 1'b0;
    end else if (cmd.acc_en && rd_vld_r) begin
      acc_first_r <= 1'b0;
      if (rd_level != 8'd0) lit_r <= 1'b1;
      if (acc_first_r ||
          ((op_r == gdc_pkg::CMD_INCREASE) && (rd_level < acc_lvl_r)) ||
          ((op_r == gdc_pkg::CMD_DECREASE) && (rd_level >= acc_lvl_r))) begin
        acc_lvl_r <= rd_level;
        acc_idx_r <= rd_idx_r;
      end
    end
  end

  // Send timer: idle counter, pending mark and countdown.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      cnt_r     <= '0;
      idle_r    <= gdc_pkg::IDLE_MAX;
    end else begin
      if (cmd.tick) begin
        if (idle_r != gdc_pkg::IDLE_MAX) idle_r <= idle_r + 17'd1;
        if (pending_r) begin
          if (cnt_r == 16'd0) pending_r <= 1'b0;
          else cnt_r <= cnt_r - 16'd1;
        end
      end
      if (cmd.sched) begin
        pending_r <= 1'b1;
        cnt_r     <= timeout_ticks;
      end
      if (cmd.idle_clr) idle_r <= '0;
    end
  end

  // Result register; a new transfer may load as the previous one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_member_r <= cur8[3:0];
      out_level_r  <= rd_level;
      out_last_r   <= !more_dirty;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_member_res = out_member_r;
  assign out_level_res  = out_level_r;
  assign out_last       = out_last_r;

  // Status to the controller.
  assign st.cur_done  = (cursor_r >= n_use);
  assign st.rd_vld    = rd_vld_r;
  assign st.dirty_cur = dirty_r[cur_idx];
  assign st.pending   = pending_r;
  assign st.cnt_zero  = (cnt_r == 16'd0);
  assign st.idle_gt   = (idle_r > {1'b0, timeout_ticks});
  assign st.rpt_ok    = !pending_r && st.idle_gt && (mbr8 < 8'(n_use));
  assign st.out_free  = !out_valid_r || !out_stall;
  assign st.op_toggle = (op_r == gdc_pkg::CMD_TOGGLE);

endmodule

`default_nettype wire

>>> design/group_dimmer_controller_core.sv
// Group dimmer controller: keeps a brightness and a dirty mark per lamp and turns
// toggle, increase and decrease commands into bursts of lamp sends, spaced by a
// tick-based timeout. One item is taken at a time; in_stall is high while an item
// is at work. A report, an unknown command or a tick that fires nothing is taken
// with no stall. Increase and decrease hold in_stall after their transfer while the
// single read port of the level store is swept once per scan, and toggle then also
// writes every lamp in use. A send burst, started at once by a command or by a tick
// that fires a pending send, steps through every lamp in use and reads and sends
// each dirty one, waiting while out_stall holds a result. Depends on gdc_pkg,
// gdc_ctrl and gdc_datapath; configuration registers sit at byte addresses 0, 4
// and 8.
`default_nettype none

module group_dimmer_controller_core #(
  parameter int MEMBERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [3:0]  in_member,
  input  wire logic [7:0]  in_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_member_res,
  output logic [7:0]       out_level_res,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]          timeout_r;
  logic [4:0]           count_r;
  logic [7:0]           max_r;
  logic                 cfg_wr;
  gdc_pkg::gdc_cmd_t    ctl_cmd;
  gdc_pkg::gdc_status_t dp_st;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= gdc_pkg::TIMEOUT_RESET;
      count_r   <= gdc_pkg::COUNT_RESET;
      max_r     <= gdc_pkg::MAX_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        gdc_pkg::REG_TIMEOUT: timeout_r <= pwdata[15:0];
        gdc_pkg::REG_COUNT:   count_r   <= pwdata[4:0];
        gdc_pkg::REG_MAX:     max_r     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gdc_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_r};
      gdc_pkg::REG_COUNT:   prdata = {27'd0, count_r};
      gdc_pkg::REG_MAX:     prdata = {24'd0, max_r};
      default:              prdata = 32'd0;
    endcase
  end

  gdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .st       (dp_st),
    .cmd      (ctl_cmd)
  );

  gdc_datapath #(
    .MEMBERS (MEMBERS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .timeout_ticks  (timeout_r),
    .member_count   (count_r),
    .max_level      (max_r),
    .in_cmd         (in_cmd),
    .in_member      (in_member),
    .in_level       (in_level),
    .cmd            (ctl_cmd),
    .st             (dp_st),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_member_res (out_member_res),
    .out_level_res  (out_level_res),
    .out_last       (out_last)
  );

  // A result is never loaded while the block takes new items.
  a_no_emit_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !ctl_cmd.emit)
    else $error("result loaded while input is open");

  // A stalled result stays valid and unchanged.
  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable({out_member_res, out_level_res, out_last})))
    else $error("stalled result changed");

  // A tick that expires the pending send starts a burst.
  a_tick_fires_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_cmd == gdc_pkg::CMD_TICK) &&
     dp_st.pending && dp_st.cnt_zero) |=> (in_stall && !dp_st.pending))
    else $error("expired send did not start a burst");

endmodule

`default_nettype wire

>>> verif/tb_group_dimmer_controller_core.sv
// Self-checking testbench for group_dimmer_controller_core: directed table, then random phases.
// Lamp sends are predicted per accepted command and matched in order against the result port.
// Depends on gdc_pkg and the controller RTL only.
`default_nettype none

module tb_group_dimmer_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLAMP = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int PLAN_ROWS = 30;

  // Command codes the block does not define; they must be ignored.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [3:0] member;
    logic [7:0] level;
    logic       is_last;
  } lamp_send_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  cmd;
    logic [3:0]  member;
    logic [7:0]  level;
    bit          typed;
    int          n_sends;
    logic [7:0]  send_lvl;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [3:0]  in_member;
  logic [7:0]  in_level;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_member_res;
  logic [7:0]  out_level_res;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the controller state and registers.
  logic [7:0]  lamp_lvl [NLAMP];
  logic        lamp_drt [NLAMP];
  logic        pend;
  logic [15:0] cdown;
  logic [16:0] idle_cnt;
  logic [15:0] r_timeout;
  logic [4:0]  r_count;
  logic [7:0]  r_max;

  lamp_send_t  fresh_sends [$];
  lamp_send_t  sends_due [$];

  // Handshake bookkeeping shared by the driver and the monitor.
  bit          in_taken;
  bit          typed_on;
  int          typed_n;
  logic [7:0]  typed_lvl;
  int          burst_left;
  int          fail_cnt;
  int          items_done;
  int          sends_seen;
  int          reg_writes;

  plan_row_t   plan [PLAN_ROWS];

  group_dimmer_controller_core #(
    .MEMBERS(NLAMP)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_member      (in_member),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_member_res (out_member_res),
    .out_level_res  (out_level_res),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR %0t: %s", $time, msg);
  endtask

  // Lamp count in use: zero means one lamp, anything above the group size saturates.
  function automatic int lamps_used();
    if (r_count == 5'd0) return 1;
    if (r_count > NLAMP) return NLAMP;
    return int'(r_count);
  endfunction

  // Sends every dirty lamp in use, in rising order, and restarts the idle count.
  task automatic flush_dirty();
    int n;
    lamp_send_t s;
    n = lamps_used();
    for (int i = 0; i < n; i++) begin
      if (lamp_drt[i]) begin
        s.member = i[3:0];
        s.level = lamp_lvl[i];
        s.is_last = 1'b0;
        fresh_sends = {fresh_sends, s};
        lamp_drt[i] = 1'b0;
      end
    end
    if (fresh_sends.size() > 0) fresh_sends[fresh_sends.size() - 1].is_last = 1'b1;
    idle_cnt = '0;
  endtask

  // Sends at once when idle long enough, otherwise arms one delayed send.
  task automatic request_send();
    if (pend) return;
    if (idle_cnt > {1'b0, r_timeout}) begin
      flush_dirty();
    end else begin
      pend = 1'b1;
      cdown = r_timeout;
    end
  endtask

  // Applies one accepted command to the shadow state; the sends it causes land in fresh_sends.
  task automatic predict_item(input logic [2:0] c, input logic [3:0] m, input logic [7:0] l);
    int n;
    int pick;
    logic [7:0] best;
    logic lit;
    n = lamps_used();
    fresh_sends.delete();
    case (c)
      gdc_pkg::CMD_TOGGLE: begin
        lit = 1'b0;
        for (int i = 0; i < n; i++) if (lamp_lvl[i] != 8'd0) lit = 1'b1;
        for (int i = 0; i < n; i++) begin
          lamp_lvl[i] = lit ? 8'd0 : r_max;
          lamp_drt[i] = 1'b1;
        end
        request_send();
      end
      gdc_pkg::CMD_INCREASE: begin
        // The dimmest lamp wins; ties go to the lowest index.
        pick = 0;
        best = lamp_lvl[0];
        for (int i = 1; i < n; i++) begin
          if (lamp_lvl[i] < best) begin
            best = lamp_lvl[i];
            pick = i;
          end
        end
        if (best < r_max) begin
          lamp_lvl[pick] = best + 8'd1;
          lamp_drt[pick] = 1'b1;
        end
        request_send();
      end
      gdc_pkg::CMD_DECREASE: begin
        // The brightest lamp wins; ties go to the highest index.
        pick = n - 1;
        best = lamp_lvl[n - 1];
        for (int i = n - 2; i >= 0; i--) begin
          if (lamp_lvl[i] > best) begin
            best = lamp_lvl[i];
            pick = i;
          end
        end
        if (best > 8'd0) begin
          lamp_lvl[pick] = best - 8'd1;
          lamp_drt[pick] = 1'b1;
        end
        request_send();
      end
      gdc_pkg::CMD_REPORT: begin
        if (!pend && idle_cnt > {1'b0, r_timeout} && int'(m) < n) begin
          lamp_lvl[m] = l;
          lamp_drt[m] = 1'b0;
        end
      end
      gdc_pkg::CMD_TICK: begin
        if (idle_cnt != gdc_pkg::IDLE_MAX) idle_cnt = idle_cnt + 17'd1;
        if (pend) begin
          if (cdown == 16'd0) begin
            pend = 1'b0;
            flush_dirty();
          end else begin
            cdown = cdown - 16'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Monitor: input transfers feed the predictor, result transfers are matched in order.
  always @(posedge clk) begin
    lamp_send_t got;
    lamp_send_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      predict_item(in_cmd, in_member, in_level);
      if (typed_on) begin
        for (int k = 0; k < typed_n; k++) begin
          want.member = k[3:0];
          want.level = typed_lvl;
          want.is_last = (k == typed_n - 1);
          sends_due = {sends_due, want};
        end
      end else begin
        sends_due = {sends_due, fresh_sends};
      end
      items_done++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = {out_member_res, out_level_res, out_last};
      sends_seen++;
      if (sends_due.size() == 0) begin
        log_fail($sformatf("unexpected send: lamp %0d level %0d last %b",
                           got.member, got.level, got.is_last));
      end else begin
        want = sends_due.pop_front();
        if (got !== want)
          log_fail($sformatf("send mismatch: expected lamp %0d level %0d last %b, got %0d %0d %b",
                             want.member, want.level, want.is_last,
                             got.member, got.level, got.is_last));
      end
    end
  end

  // Result side stalls: modes of no stall, scattered stalls and long stall runs.
  initial begin
    int mode;
    int span;
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(16, 64);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 2) == 0);
          default: begin
            if (hold == 0) begin
              out_stall = ~out_stall;
              hold = $urandom_range(1, 8);
            end
            hold--;
          end
        endcase
      end
    end
  end

  // Presents one command and holds it until its transfer; bursts are separated by random gaps.
  task automatic push_item(input logic [2:0] c, input logic [3:0] m, input logic [7:0] l,
                           input bit typed = 1'b0, input int n_typed = 0,
                           input logic [7:0] lvl_typed = 8'd0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_cmd = c;
    in_member = m;
    in_level = l;
    typed_on = typed;
    typed_n = n_typed;
    typed_lvl = lvl_typed;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_taken);
  endtask

  // Stops sending, waits for every expected send, then lets a silent command finish.
  task automatic settle();
    in_valid = 1'b0;
    burst_left = 0;
    while (sends_due.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] held;
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {16'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      gdc_pkg::REG_TIMEOUT: r_timeout = val;
      gdc_pkg::REG_COUNT:   r_count = val[4:0];
      default:              r_max = val[7:0];
    endcase
    case (idx)
      gdc_pkg::REG_TIMEOUT: held = {16'd0, r_timeout};
      gdc_pkg::REG_COUNT:   held = {27'd0, r_count};
      default:              held = {24'd0, r_max};
    endcase
    reg_writes++;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== held)
      log_fail($sformatf("register %0d read back %0h, expected %0h", idx, prdata, held));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic plan_row_t cmd_row(input logic [2:0] c, input logic [3:0] m,
                                        input logic [7:0] l);
    plan_row_t r;
    r = '{kind: ROW_ITEM, cmd: c, member: m, level: l, typed: 1'b0, n_sends: 0,
          send_lvl: 8'd0, reg_idx: 2'd0, reg_val: 16'd0};
    return r;
  endfunction

  // A row whose sends are known outright: lamps 0 to n-1, all at one level.
  function automatic plan_row_t sent_row(input logic [2:0] c, input logic [3:0] m,
                                         input logic [7:0] l, input int n,
                                         input logic [7:0] lvl);
    plan_row_t r;
    r = cmd_row(c, m, l);
    r.typed = 1'b1;
    r.n_sends = n;
    r.send_lvl = lvl;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t r;
    r = cmd_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [7:0] report_level();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, r_max));
  endfunction

  // Time limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Run stopped at the time limit with %0d sends still expected.", sends_due.size());
    $display("** group_dimmer_controller_core: FAILED **");
    $finish;
  end

  initial begin
    int done_here;
    int pick;
    int n;
    logic [2:0] c;
    logic [15:0] ph_timeout;
    logic [4:0] ph_count;
    logic [7:0] ph_max;

    // Inputs idle, shadow state at its reset values.
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = gdc_pkg::CMD_TICK;
    in_member = 4'd0;
    in_level = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    typed_on = 1'b0;
    typed_n = 0;
    typed_lvl = 8'd0;
    burst_left = 0;
    fail_cnt = 0;
    items_done = 0;
    sends_seen = 0;
    reg_writes = 0;
    for (int i = 0; i < NLAMP; i++) begin
      lamp_lvl[i] = 8'd0;
      lamp_drt[i] = 1'b0;
    end
    pend = 1'b0;
    cdown = 16'd0;
    idle_cnt = gdc_pkg::IDLE_MAX;
    r_timeout = gdc_pkg::TIMEOUT_RESET;
    r_count = gdc_pkg::COUNT_RESET;
    r_max = gdc_pkg::MAX_RESET;

    // Directed table: reset behavior, timing windows, rejected reports and register extremes.
    plan = '{
      sent_row(gdc_pkg::CMD_TOGGLE, 4'd0, 8'd0, 16, 8'd255),
      sent_row(gdc_pkg::CMD_REPORT, 4'd3, 8'd7, 0, 8'd0),
      sent_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0, 0, 8'd0),
      cfg_row(gdc_pkg::REG_TIMEOUT, 16'hFFFF),
      sent_row(gdc_pkg::CMD_REPORT, 4'd4, 8'd200, 0, 8'd0),
      cfg_row(gdc_pkg::REG_TIMEOUT, 16'd0),
      cmd_row(gdc_pkg::CMD_DECREASE, 4'd15, 8'd255),
      cmd_row(gdc_pkg::CMD_INCREASE, 4'd0, 8'd0),
      sent_row(gdc_pkg::CMD_REPORT, 4'd1, 8'd1, 0, 8'd0),
      cmd_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0),
      cmd_row(gdc_pkg::CMD_TOGGLE, 4'd0, 8'd0),
      sent_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0, 16, 8'd0),
      cmd_row(gdc_pkg::CMD_DECREASE, 4'd0, 8'd0),
      sent_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0, 0, 8'd0),
      cmd_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0),
      cmd_row(gdc_pkg::CMD_REPORT, 4'd2, 8'd9),
      cfg_row(gdc_pkg::REG_MAX, 16'd1),
      cmd_row(gdc_pkg::CMD_REPORT, 4'd5, 8'd255),
      cmd_row(gdc_pkg::CMD_INCREASE, 4'd0, 8'd0),
      cmd_row(gdc_pkg::CMD_DECREASE, 4'd0, 8'd0),
      sent_row(CMD_SPARE_HI, 4'd15, 8'd255, 0, 8'd0),
      cmd_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0),
      cmd_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0),
      cfg_row(gdc_pkg::REG_COUNT, 16'd0),
      sent_row(gdc_pkg::CMD_REPORT, 4'd1, 8'd3, 0, 8'd0),
      sent_row(gdc_pkg::CMD_TOGGLE, 4'd0, 8'd0, 1, 8'd0),
      cfg_row(gdc_pkg::REG_COUNT, 16'd31),
      cfg_row(gdc_pkg::REG_MAX, 16'd255),
      cmd_row(gdc_pkg::CMD_TOGGLE, 4'd0, 8'd0),
      sent_row(gdc_pkg::CMD_TICK, 4'd0, 8'd0, 16, 8'd0)
    };

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_REG) begin
        settle();
        reg_write(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        push_item(plan[r].cmd, plan[r].member, plan[r].level,
                  plan[r].typed, plan[r].n_sends, plan[r].send_lvl);
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ph_timeout = 16'd1; ph_count = 5'd1;  ph_max = 8'd255; end
        1: begin ph_timeout = 16'd3; ph_count = 5'd16; ph_max = 8'd1;   end
        2: begin ph_timeout = 16'd0; ph_count = 5'd17; ph_max = 8'd2;   end
        3: begin ph_timeout = 16'd2; ph_count = 5'd2;  ph_max = 8'd255; end
        default: begin
          ph_timeout = 16'($urandom_range(0, 6));
          ph_count = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 16));
          ph_max = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                               : 8'($urandom_range(1, 255));
        end
      endcase
      settle();
      reg_write(gdc_pkg::REG_TIMEOUT, ph_timeout);
      reg_write(gdc_pkg::REG_COUNT, {11'd0, ph_count});
      reg_write(gdc_pkg::REG_MAX, {8'd0, ph_max});

      done_here = 0;
      while (done_here < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        n = lamps_used();
        if (pick < 2) begin
          // Enough ticks to fire any pending send and go idle, then readback reports.
          repeat (2 * int'(ph_timeout) + 3) begin
            push_item(gdc_pkg::CMD_TICK, 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
            done_here++;
          end
          repeat ($urandom_range(1, 3)) begin
            push_item(gdc_pkg::CMD_REPORT, 4'($urandom_range(0, n - 1)), report_level());
            done_here++;
          end
        end else if (pick == 2) begin
          // Noise: undefined commands and reports aimed at any lamp.
          if ($urandom_range(0, 1) == 0) begin
            push_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
          end else begin
            push_item(gdc_pkg::CMD_REPORT, 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)));
            done_here++;
          end
        end else begin
          if (pick <= 8) c = gdc_pkg::CMD_TICK;
          else if (pick <= 10) c = gdc_pkg::CMD_TOGGLE;
          else if (pick <= 14) c = gdc_pkg::CMD_INCREASE;
          else if (pick <= 18) c = gdc_pkg::CMD_DECREASE;
          else c = gdc_pkg::CMD_REPORT;
          if (c == gdc_pkg::CMD_REPORT)
            push_item(c, 4'($urandom_range(0, n - 1)), report_level());
          else
            push_item(c, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
          done_here++;
        end
        // Now and then hold off until every expected send has drained.
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    if (sends_due.size() > 0) log_fail($sformatf("%0d sends never arrived", sends_due.size()));

    $display("Covered %0d accepted commands and %0d register writes; %0d lamp sends checked.",
             items_done, reg_writes, sends_seen);
    if (fail_cnt == 0) begin
      $display("** group_dimmer_controller_core: PASSED **");
    end else begin
      $display("%0d mismatches in total.", fail_cnt);
      $display("** group_dimmer_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
